[hdl/gcd_pkg.sv]
// Package with shared types, constants and arithmetic helpers for the distance unit.
`default_nettype none
package gcd_pkg;

    localparam int FRAC = 29;
    localparam logic signed [63:0] ONE_Q = 64'sd536870912;
    localparam logic signed [63:0] PI_Q = 64'sd1686629713;
    localparam logic signed [63:0] HALF_PI_Q = 64'sd843314857;
    localparam logic signed [63:0] GAIN_INV_Q = 64'sd326016437;
    localparam logic [31:0] DEG_TO_RAD_K = 32'd1006113814;
    localparam logic [22:0] RADIUS_RESET = 23'd6371000;
    localparam int ISQRT_STEPS = 32;

    // Register indexes of the configuration port.
    localparam logic [0:0] REG_RADIUS = 1'b0;

    // Mode of a CORDIC cell.
    typedef enum logic {
        t_rot = 1'b0,
        t_vec = 1'b1
    } t_cordic_mode;

    // One lane of a CORDIC chain.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_cordic_lane;

    // Arctangent table, Q29.
    function automatic logic signed [33:0] atan_step(input int i);
        logic signed [33:0] v;
        v = '0;
        case (i)
            0: v = 34'sd421657428;
            1: v = 34'sd248918915;
            2: v = 34'sd131521918;
            3: v = 34'sd66762579;
            4: v = 34'sd33510843;
            5: v = 34'sd16771758;
            6: v = 34'sd8387925;
            7: v = 34'sd4194219;
            8: v = 34'sd2097141;
            9: v = 34'sd1048575;
            default: begin
                if (i < 30) v = 34'sd1 <<< (FRAC - i);
                else v = '0;
            end
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[hdl/gcd_cordic_cell.sv]
// One CORDIC micro-rotation cell with registered outputs and side-band payload.
`default_nettype none
module gcd_cordic_cell #(
    parameter int STAGE = 0,
    parameter int SIDE_W = 1
) (
    input  wire logic                      i_clk,
    input  wire gcd_pkg::t_cordic_mode     i_mode,
    input  wire gcd_pkg::t_cordic_lane     i_lane,
    input  wire logic                      i_flip,
    input  wire logic [SIDE_W-1:0]         i_side,
    output gcd_pkg::t_cordic_lane          o_lane,
    output logic                           o_flip,
    output logic [SIDE_W-1:0]              o_side
);
    gcd_pkg::t_cordic_lane r_lane, n_lane;
    logic r_flip;
    logic [SIDE_W-1:0] r_side;
    logic signed [33:0] dx, dy, at;
    logic dir;

    // Rotate toward zero angle or toward the x axis depending on mode.
    always_comb begin
        dx = i_lane.y >>> STAGE;
        dy = i_lane.x >>> STAGE;
        at = gcd_pkg::atan_step(STAGE);
        if (i_mode == gcd_pkg::t_rot) dir = ~i_lane.z[33];
        else dir = i_lane.y[33];
        n_lane = i_lane;
        if (i_mode == gcd_pkg::t_rot) begin
            if (dir) begin
                n_lane.x = i_lane.x - dx; n_lane.y = i_lane.y + dy; n_lane.z = i_lane.z - at;
            end else begin
                n_lane.x = i_lane.x + dx; n_lane.y = i_lane.y - dy; n_lane.z = i_lane.z + at;
            end
        end else begin
            if (!dir) begin
                n_lane.x = i_lane.x + dx; n_lane.y = i_lane.y - dy; n_lane.z = i_lane.z + at;
            end else begin
                n_lane.x = i_lane.x - dx; n_lane.y = i_lane.y + dy; n_lane.z = i_lane.z - at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
        r_flip <= i_flip;
        r_side <= i_side;
    end

    assign o_lane = r_lane;
    assign o_flip = r_flip;
    assign o_side = r_side;
endmodule
`default_nettype wire

[hdl/gcd_isqrt_cell.sv]
// One digit step of a pipelined integer square root with side-band payload.
`default_nettype none
module gcd_isqrt_cell #(
    parameter int STEP = 0,
    parameter int SIDE_W = 1
) (
    input  wire logic               i_clk,
    input  wire logic [63:0]        i_rem,
    input  wire logic [63:0]        i_root,
    input  wire logic [SIDE_W-1:0]  i_side,
    output logic [63:0]             o_rem,
    output logic [63:0]             o_root,
    output logic [SIDE_W-1:0]       o_side
);
    logic [63:0] r_rem, r_root, n_rem, n_root, bitv, trial;
    logic [SIDE_W-1:0] r_side;

    // Classic bit-pair restoring step; bit position is fixed by the stage.
    always_comb begin
        bitv = 64'd1 << (62 - 2 * STEP);
        trial = i_root + bitv;
        if (i_rem >= trial) begin
            n_rem = i_rem - trial;
            n_root = (i_root >> 1) + bitv;
        end else begin
            n_rem = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_root <= n_root;
        r_side <= i_side;
    end

    assign o_rem = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;
endmodule
`default_nettype wire

[hdl/great_circle_distance_unit.sv]
// Top level: pipelined haversine great-circle distance with APB radius register.
// Throughput: one item per cycle; busy is tied low since every stage is a register.
// The latency is set by two CORDIC chains and the 32-step square root chain.
// Synchronous active-low reset clears the valid chain and sets radius to 6371000.
`default_nettype none
module great_circle_distance_unit #(
    parameter int CORDIC_STAGES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [30:0] i_first_lat,
    input  wire logic signed [30:0] i_second_lat,
    input  wire logic signed [31:0] i_first_lon,
    input  wire logic signed [31:0] i_second_lon,
    output logic                    o_valid,
    output logic [24:0]             o_distance_m,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    localparam int LAT = 2 * CORDIC_STAGES + 40;

    // Configuration register.
    logic [22:0] r_radius;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= gcd_pkg::RADIUS_RESET;
        end else if (psel && penable && pwrite && paddr[1] == gcd_pkg::REG_RADIUS) begin
            r_radius <= pwdata[22:0];
        end
    end
    assign prdata = (paddr[1] == gcd_pkg::REG_RADIUS) ? {9'd0, r_radius} : 32'd0;
    assign pready = 1'b1;
    assign busy = 1'b0;

    // Valid chain.
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else r_vld <= {r_vld[LAT-2:0], start};
    end
    assign o_valid = r_vld[LAT-1];

    // Stage 1: degree magnitudes times constant.
    logic [31:0] m_in [4];
    logic        s_in [4];
    logic [63:0] r_prod [4];
    logic        r_sgn [4];
    always_comb begin
        s_in[0] = i_first_lat[30];
        m_in[0] = s_in[0] ? 32'(-33'(i_first_lat)) : 32'(i_first_lat);
        s_in[1] = i_second_lat[30];
        m_in[1] = s_in[1] ? 32'(-33'(i_second_lat)) : 32'(i_second_lat);
        s_in[2] = i_first_lon[31];
        m_in[2] = s_in[2] ? 32'(-33'(i_first_lon)) : 32'(i_first_lon);
        s_in[3] = i_second_lon[31];
        m_in[3] = s_in[3] ? 32'(-33'(i_second_lon)) : 32'(i_second_lon);
    end
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_prod[k] <= 64'(m_in[k]) * 64'(gcd_pkg::DEG_TO_RAD_K);
            r_sgn[k]  <= s_in[k];
        end
    end

    // Stage 2: radians with sign.
    logic signed [33:0] rad [4];
    logic signed [33:0] r_rad [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rad[k] = r_sgn[k] ? -34'(r_prod[k] >> 30) : 34'(r_prod[k] >> 30);
        end
    end
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) r_rad[k] <= rad[k];
    end

    // Stage 3: half differences, both latitudes as they are, and range fold.
    logic signed [33:0] ang [4], fz [4];
    logic               ff [4];
    gcd_pkg::t_cordic_lane r_l0 [4];
    logic               r_f0 [4];
    always_comb begin
        ang[0] = 34'((35'(r_rad[1]) - 35'(r_rad[0])) >>> 1);
        ang[1] = 34'((35'(r_rad[3]) - 35'(r_rad[2])) >>> 1);
        ang[2] = r_rad[0];
        ang[3] = r_rad[1];
        for (int k = 0; k < 4; k++) begin
            ff[k] = 1'b0;
            fz[k] = ang[k];
            if (64'(ang[k]) > gcd_pkg::HALF_PI_Q) begin
                fz[k] = 34'(gcd_pkg::PI_Q) - ang[k]; ff[k] = 1'b1;
            end else if (64'(ang[k]) < -gcd_pkg::HALF_PI_Q) begin
                fz[k] = -34'(gcd_pkg::PI_Q) - ang[k]; ff[k] = 1'b1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_l0[k].x <= 34'(gcd_pkg::GAIN_INV_Q);
            r_l0[k].y <= '0;
            r_l0[k].z <= fz[k];
            r_f0[k] <= ff[k];
        end
    end

    // Rotation chains for the four angles.
    gcd_pkg::t_cordic_lane rl [4][CORDIC_STAGES+1];
    logic                  rf [4][CORDIC_STAGES+1];
    logic [0:0]            rs [4][CORDIC_STAGES+1];
    genvar g, s;
    generate
        for (g = 0; g < 4; g++) begin : g_rot
            assign rl[g][0] = r_l0[g];
            assign rf[g][0] = r_f0[g];
            assign rs[g][0] = 1'b0;
            for (s = 0; s < CORDIC_STAGES; s++) begin : g_cell
                gcd_cordic_cell #(.STAGE(s), .SIDE_W(1)) u_cell (
                    .i_clk(i_clk), .i_mode(gcd_pkg::t_rot),
                    .i_lane(rl[g][s]), .i_flip(rf[g][s]), .i_side(rs[g][s]),
                    .o_lane(rl[g][s+1]), .o_flip(rf[g][s+1]), .o_side(rs[g][s+1])
                );
            end
        end
    endgenerate

    // Products: squares and cosine product.
    logic signed [33:0] sdl, sdo, c1, c2;
    logic signed [67:0] r_p_sdl, r_p_sdo, r_p_cc;
    always_comb begin
        sdl = rl[0][CORDIC_STAGES].y;
        sdo = rl[1][CORDIC_STAGES].y;
        c1 = rf[2][CORDIC_STAGES] ? -rl[2][CORDIC_STAGES].x : rl[2][CORDIC_STAGES].x;
        c2 = rf[3][CORDIC_STAGES] ? -rl[3][CORDIC_STAGES].x : rl[3][CORDIC_STAGES].x;
    end
    always_ff @(posedge i_clk) begin
        r_p_sdl <= 68'(sdl) * 68'(sdl);
        r_p_sdo <= 68'(sdo) * 68'(sdo);
        r_p_cc  <= 68'(c1) * 68'(c2);
    end

    logic signed [33:0] r_q_sdl, r_q_sdo, r_q_cc;
    always_ff @(posedge i_clk) begin
        r_q_sdl <= 34'(r_p_sdl >>> gcd_pkg::FRAC);
        r_q_sdo <= 34'(r_p_sdo >>> gcd_pkg::FRAC);
        r_q_cc  <= 34'(r_p_cc >>> gcd_pkg::FRAC);
    end

    logic signed [67:0] r_p_h;
    logic signed [33:0] r_q_sdl2;
    always_ff @(posedge i_clk) begin
        r_p_h <= 68'(r_q_cc) * 68'(r_q_sdo);
        r_q_sdl2 <= r_q_sdl;
    end

    // Haversine term with clamp.
    logic signed [35:0] a_sum;
    logic [29:0] a_cl;
    logic [29:0] r_a;
    always_comb begin
        a_sum = 36'(r_q_sdl2) + 36'(r_p_h >>> gcd_pkg::FRAC);
        if (a_sum < 0) a_cl = '0;
        else if (a_sum > 36'(gcd_pkg::ONE_Q)) a_cl = 30'(gcd_pkg::ONE_Q);
        else a_cl = a_sum[29:0];
    end
    always_ff @(posedge i_clk) r_a <= a_cl;

    // Two square root chains run side by side.
    logic [63:0] qa_rem [gcd_pkg::ISQRT_STEPS+1], qa_root [gcd_pkg::ISQRT_STEPS+1];
    logic [63:0] qb_rem [gcd_pkg::ISQRT_STEPS+1], qb_root [gcd_pkg::ISQRT_STEPS+1];
    logic [0:0]  qa_s [gcd_pkg::ISQRT_STEPS+1], qb_s [gcd_pkg::ISQRT_STEPS+1];
    assign qa_rem[0] = {5'd0, r_a, 29'd0};
    assign qb_rem[0] = {5'd0, 30'(30'(gcd_pkg::ONE_Q) - r_a), 29'd0};
    assign qa_root[0] = '0;
    assign qb_root[0] = '0;
    assign qa_s[0] = 1'b0;
    assign qb_s[0] = 1'b0;
    generate
        for (s = 0; s < gcd_pkg::ISQRT_STEPS; s++) begin : g_sq
            gcd_isqrt_cell #(.STEP(s), .SIDE_W(1)) u_a (
                .i_clk(i_clk), .i_rem(qa_rem[s]), .i_root(qa_root[s]), .i_side(qa_s[s]),
                .o_rem(qa_rem[s+1]), .o_root(qa_root[s+1]), .o_side(qa_s[s+1])
            );
            gcd_isqrt_cell #(.STEP(s), .SIDE_W(1)) u_b (
                .i_clk(i_clk), .i_rem(qb_rem[s]), .i_root(qb_root[s]), .i_side(qb_s[s]),
                .o_rem(qb_rem[s+1]), .o_root(qb_root[s+1]), .o_side(qb_s[s+1])
            );
        end
    endgenerate

    // Vectoring chain for the central angle; radius rides alongside.
    gcd_pkg::t_cordic_lane vl [CORDIC_STAGES+1];
    logic                  vf [CORDIC_STAGES+1];
    logic [22:0]           vs [CORDIC_STAGES+1];
    assign vl[0].x = 34'(qb_root[gcd_pkg::ISQRT_STEPS]);
    assign vl[0].y = 34'(qa_root[gcd_pkg::ISQRT_STEPS]);
    assign vl[0].z = '0;
    assign vf[0] = qa_s[gcd_pkg::ISQRT_STEPS] ^ qb_s[gcd_pkg::ISQRT_STEPS];
    assign vs[0] = r_radius;
    generate
        for (s = 0; s < CORDIC_STAGES; s++) begin : g_vec
            gcd_cordic_cell #(.STAGE(s), .SIDE_W(23)) u_cell (
                .i_clk(i_clk), .i_mode(gcd_pkg::t_vec),
                .i_lane(vl[s]), .i_flip(vf[s]), .i_side(vs[s]),
                .o_lane(vl[s+1]), .o_flip(vf[s+1]), .o_side(vs[s+1])
            );
        end
    endgenerate

    // Scale by radius.
    logic [33:0] cang;
    logic [57:0] r_dist;
    always_comb begin
        if (vl[CORDIC_STAGES].z[33] || vf[CORDIC_STAGES]) cang = '0;
        else cang = 34'(vl[CORDIC_STAGES].z) << 1;
    end
    always_ff @(posedge i_clk) begin
        r_dist <= 58'(vs[CORDIC_STAGES]) * 58'(cang);
    end
    assign o_distance_m = 25'(r_dist >> gcd_pkg::FRAC);
endmodule
`default_nettype wire
